FILE: rtl/core/swmq_pkg.sv
// Shared types and constants of the sliding window mean queue.
// Used by swmq_ctrl, swmq_datapath and sliding_window_mean_queue_unit.
package swmq_pkg;

  localparam int DEF_WINDOW_MAX  = 16;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_FRAC_BITS   = 8;

  localparam int COUNT_BITS = 5;
  localparam int MEAN_BITS  = 24;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;

  localparam logic [COUNT_BITS-1:0]  WS_RESET        = 5'd4;
  localparam logic [ADDR_BITS-3:0]   REG_WINDOW_SIZE = 1'b0;

  typedef enum logic [1:0] {
    OP_SLIDE_PUSH = 2'd0,
    OP_PUSH       = 2'd1,
    OP_POP        = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_FRONT,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic rd_head;
    logic remove_step;
    logic insert_step;
    logic div_start;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/core/swmq_ctrl.sv
// Sequencing state machine of the sliding window mean queue.
// Depends on swmq_pkg; drives the command struct of swmq_datapath.
module swmq_ctrl import swmq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_REMOVE;
        end
      end
      ST_REMOVE: state_next = ST_INSERT;
      ST_INSERT: state_next = ST_FRONT;
      ST_FRONT:  state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (status.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall     = 1'b0;
        cmd.load_item = req_valid;
        cmd.rd_head   = req_valid;
      end
      ST_REMOVE: cmd.remove_step = 1'b1;
      ST_INSERT: cmd.insert_step = 1'b1;
      ST_FRONT: begin
        cmd.rd_head   = 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_DONE:   cmd.load_out = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

FILE: rtl/core/swmq_datapath.sv
// Datapath of the sliding window mean queue: sample memory, running sum,
// restoring divider and result register. Depends on swmq_pkg.
module swmq_datapath import swmq_pkg::*; #(
  parameter int WINDOW_MAX  = DEF_WINDOW_MAX,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dp_cmd_t                       cmd,
  output dp_status_t                    status,
  input  logic                          cfg_write,
  input  logic [COUNT_BITS-1:0]         cfg_data,
  output logic [COUNT_BITS-1:0]         window_size,
  input  logic [1:0]                    operation,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic signed [MEAN_BITS-1:0]   mean_value,
  output logic [COUNT_BITS-1:0]         count,
  output logic signed [SAMPLE_BITS-1:0] front_value,
  output logic                          is_full,
  output logic                          is_empty
);

  localparam int IDX_BITS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
  localparam int DIV_BITS  = SUM_BITS + FRAC_BITS;
  localparam int CNT_BITS  = $clog2(DIV_BITS);
  localparam int EXT_BITS  = ((DIV_BITS > MEAN_BITS) ? DIV_BITS : MEAN_BITS) + 1;
  localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
  localparam logic [COUNT_BITS-1:0] CAP_MAX =
    COUNT_BITS'((WINDOW_MAX > COUNT_MAX) ? COUNT_MAX : WINDOW_MAX);
  localparam logic [EXT_BITS-1:0] LIM_POS = EXT_BITS'((1 << (MEAN_BITS - 1)) - 1);
  localparam logic [EXT_BITS-1:0] LIM_NEG = EXT_BITS'(1 << (MEAN_BITS - 1));

  logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] rdata;

  logic [COUNT_BITS-1:0]      head;
  logic [COUNT_BITS-1:0]      occ;
  logic signed [SUM_BITS-1:0] sum;
  op_t                        item_op;
  logic [SAMPLE_BITS-1:0]     item_sample;

  logic [DIV_BITS-1:0]   dq;
  logic [COUNT_BITS-1:0] rem;
  logic [CNT_BITS-1:0]   div_cnt;
  logic                  neg;

  logic [COUNT_BITS-1:0] cap;
  logic                  remove_ok;
  logic                  insert_ok;
  logic [COUNT_BITS-1:0] head_inc;
  logic [COUNT_BITS-1:0] head_wrap;
  logic [COUNT_BITS:0]   tail_sum;
  logic [COUNT_BITS:0]   tail_sel;
  logic [IDX_BITS-1:0]   tail_idx;
  logic [SUM_BITS-1:0]   rdata_ext;
  logic [SUM_BITS-1:0]   sample_ext;
  logic [SUM_BITS-1:0]   sum_mag;
  logic [COUNT_BITS:0]   rem_sh;
  logic [COUNT_BITS:0]   rem_diff;
  logic                  q_bit;
  logic [COUNT_BITS-1:0] rem_next;
  logic [EXT_BITS-1:0]   q_ext;
  logic [EXT_BITS-1:0]   mag_sat;
  logic [EXT_BITS-1:0]   mean_ext;

  always_comb begin
    if (window_size == '0) begin
      cap = COUNT_BITS'(1);
    end else if (window_size > CAP_MAX) begin
      cap = CAP_MAX;
    end else begin
      cap = window_size;
    end
  end

  assign remove_ok = ((item_op == OP_SLIDE_PUSH) && (occ >= cap)) ||
                     ((item_op == OP_POP) && (occ != '0));
  assign insert_ok = ((item_op == OP_SLIDE_PUSH) || (item_op == OP_PUSH)) && (occ < cap);

  assign head_inc  = head + COUNT_BITS'(1);
  assign head_wrap = (head_inc == cap) ? '0 : head_inc;
  assign tail_sum  = {1'b0, head} + {1'b0, occ};
  assign tail_sel  = (tail_sum >= {1'b0, cap}) ? (tail_sum - {1'b0, cap}) : tail_sum;
  assign tail_idx  = IDX_BITS'(tail_sel);

  assign rdata_ext  = {{COUNT_BITS{rdata[SAMPLE_BITS-1]}}, rdata};
  assign sample_ext = {{COUNT_BITS{item_sample[SAMPLE_BITS-1]}}, item_sample};
  assign sum_mag    = sum[SUM_BITS-1] ? (~sum + SUM_BITS'(1)) : sum;

  assign rem_sh   = {rem, dq[DIV_BITS-1]};
  assign q_bit    = (rem_sh >= {1'b0, occ});
  assign rem_diff = rem_sh - {1'b0, occ};
  assign rem_next = q_bit ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];

  assign q_ext = EXT_BITS'(dq);
  always_comb begin
    if (neg) begin
      mag_sat  = (q_ext > LIM_NEG) ? LIM_NEG : q_ext;
      mean_ext = ~mag_sat + EXT_BITS'(1);
    end else begin
      mag_sat  = (q_ext > LIM_POS) ? LIM_POS : q_ext;
      mean_ext = mag_sat;
    end
  end

  assign status.div_done = (div_cnt == '0);
  assign status.out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WS_RESET;
      head        <= '0;
      occ         <= '0;
      sum         <= '0;
    end else if (cfg_write) begin
      window_size <= cfg_data;
      head        <= '0;
      occ         <= '0;
      sum         <= '0;
    end else if (cmd.remove_step && remove_ok) begin
      sum  <= sum - rdata_ext;
      head <= head_wrap;
      occ  <= occ - COUNT_BITS'(1);
    end else if (cmd.insert_step && insert_ok) begin
      sum <= sum + sample_ext;
      occ <= occ + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert_step && insert_ok) begin
      mem[tail_idx] <= item_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_head) begin
      rdata <= mem[IDX_BITS'(head)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op     <= op_t'(operation);
      item_sample <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= CNT_BITS'(DIV_BITS - 1);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq  <= DIV_BITS'(sum_mag) << FRAC_BITS;
      rem <= '0;
      neg <= sum[SUM_BITS-1];
    end else if (cmd.div_step) begin
      dq  <= {dq[DIV_BITS-2:0], q_bit};
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mean_value  <= (occ == '0) ? '0 : mean_ext[MEAN_BITS-1:0];
      count       <= occ;
      front_value <= (occ == '0) ? '0 : rdata;
      is_full     <= (occ == cap);
      is_empty    <= (occ == '0);
    end
  end

  a_occ_within_cap: assert property (@(posedge clk) disable iff (rst) occ <= cap)
    else $error("occupancy exceeds capacity");

  a_head_within_cap: assert property (@(posedge clk) disable iff (rst) head < cap)
    else $error("head index outside capacity");

  a_empty_sum_zero: assert property (@(posedge clk) disable iff (rst)
    (occ == '0) |-> (sum == '0))
    else $error("running sum nonzero while empty");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!res_valid || !res_stall))
    else $error("result register overwritten while stalled");

endmodule

FILE: rtl/core/sliding_window_mean_queue_unit.sv
// Top level of the sliding window mean queue.
// Depends on swmq_pkg, swmq_ctrl and swmq_datapath.
//
// Requests arrive on req_valid/req_stall with operation and sample; each
// request yields one result on res_valid/res_stall carrying mean_value
// (signed, FRAC_BITS fraction bits, truncated toward zero), count,
// front_value, is_full and is_empty. Operation codes are slide-push,
// push (ignored when full), pop (ignored when empty) and none.
// A request is taken only while the block is idle, so a new request waits until
// the result of the last one has been written to the output register. The
// mean comes from a restoring divider that retires one quotient bit per cycle.
// The result sits in an output register, so a stalled receiver only holds
// the block once the next result is ready to be written.
// The window_size register sits at byte address 0 of the APB-style port;
// writing it empties the queue. Write it only while the block is idle.
// A synchronous reset empties the queue, sets window_size to 4 and drops
// res_valid. The sample memory has no reset and needs no clearing pass.
module sliding_window_mean_queue_unit import swmq_pkg::*; #(
  parameter int WINDOW_MAX  = DEF_WINDOW_MAX,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_BITS-1:0]          paddr,
  input  logic [DATA_BITS-1:0]          pwdata,
  output logic [DATA_BITS-1:0]          prdata,
  output logic                          pready,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    operation,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic signed [MEAN_BITS-1:0]   mean_value,
  output logic [COUNT_BITS-1:0]         count,
  output logic signed [SAMPLE_BITS-1:0] front_value,
  output logic                          is_full,
  output logic                          is_empty
);

  dp_cmd_t               cmd;
  dp_status_t            status;
  logic                  reg_hit;
  logic                  cfg_write;
  logic [COUNT_BITS-1:0] window_size;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[ADDR_BITS-1:2] == REG_WINDOW_SIZE);
  assign cfg_write = psel && penable && pwrite && pready && reg_hit;
  assign prdata    = reg_hit ? DATA_BITS'(window_size) : '0;

  swmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  swmq_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_write   (cfg_write),
    .cfg_data    (pwdata[COUNT_BITS-1:0]),
    .window_size (window_size),
    .operation   (operation),
    .sample      (sample),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .mean_value  (mean_value),
    .count       (count),
    .front_value (front_value),
    .is_full     (is_full),
    .is_empty    (is_empty)
  );

endmodule

FILE: test/sliding_window_mean_queue_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_mean_queue_unit: a directed request table,
// then random requests over several window sizes, each result checked against a listed
// or predicted value. Depends on swmq_pkg and the RTL of the queue unit.
module sliding_window_mean_queue_unit_tb;
  import swmq_pkg::*;

  localparam int DEPTH           = DEF_WINDOW_MAX;
  localparam int QUIET_LIMIT     = 5000;
  localparam int HOLD_CYCLES     = 600;
  localparam int HOLD_AFTER      = 150;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int DRAIN_CYCLES    = 50;

  typedef struct packed {
    logic signed [MEAN_BITS-1:0]       mean;
    logic [COUNT_BITS-1:0]             cnt;
    logic signed [DEF_SAMPLE_BITS-1:0] front;
    logic                              full;
    logic                              empty;
  } stats_t;

  typedef enum logic {ROW_REQUEST, ROW_WINDOW} row_kind_t;

  typedef struct {
    row_kind_t                         kind;
    logic [COUNT_BITS-1:0]             window;
    op_t                               op;
    logic signed [DEF_SAMPLE_BITS-1:0] smp;
    bit                                typed;
    stats_t                            want;
  } row_t;

  logic                              clk;
  logic                              rst;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [ADDR_BITS-1:0]              paddr;
  logic [DATA_BITS-1:0]              pwdata;
  logic [DATA_BITS-1:0]              prdata;
  logic                              pready;
  logic                              req_valid;
  logic                              req_stall;
  logic [1:0]                        operation;
  logic signed [DEF_SAMPLE_BITS-1:0] sample;
  logic                              res_valid;
  logic                              res_stall;
  logic signed [MEAN_BITS-1:0]       mean_value;
  logic [COUNT_BITS-1:0]             count;
  logic signed [DEF_SAMPLE_BITS-1:0] front_value;
  logic                              is_full;
  logic                              is_empty;

  sliding_window_mean_queue_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall), .operation(operation), .sample(sample),
    .res_valid(res_valid), .res_stall(res_stall), .mean_value(mean_value), .count(count),
    .front_value(front_value), .is_full(is_full), .is_empty(is_empty)
  );

  logic signed [DEF_SAMPLE_BITS-1:0] win_samples [DEPTH];
  int                                win_head;
  int                                win_count;
  longint                            win_sum;
  logic [COUNT_BITS-1:0]             win_reg;

  stats_t expected_stats [$];
  row_t   rows [$];
  int     requests_sent;
  int     results_checked;
  int     mismatches;
  int     window_writes;
  int     quiet_cycles;
  bit     no_idle;
  bit     hold_done;

  always #5 clk = ~clk;

  function automatic int window_capacity();
    if (win_reg == 0) return 1;
    if (win_reg > DEPTH) return DEPTH;
    return int'(win_reg);
  endfunction

  function automatic void drop_oldest();
    if (win_count == 0) return;
    win_sum -= win_samples[win_head];
    win_head = (win_head + 1) % window_capacity();
    win_count--;
  endfunction

  function automatic void append_sample(logic signed [DEF_SAMPLE_BITS-1:0] s);
    int tail;
    if (win_count >= window_capacity()) return;
    tail = (win_head + win_count) % window_capacity();
    win_samples[tail] = s;
    win_sum += s;
    win_count++;
  endfunction

  function automatic stats_t compute_window_stats(op_t op, logic signed [DEF_SAMPLE_BITS-1:0] s);
    stats_t r;
    longint mag;
    longint q;
    case (op)
      OP_SLIDE_PUSH: begin
        if (win_count >= window_capacity()) drop_oldest();
        append_sample(s);
      end
      OP_PUSH: append_sample(s);
      OP_POP: drop_oldest();
      default: ;
    endcase
    q = 0;
    if (win_count != 0) begin
      mag = (win_sum < 0) ? -win_sum : win_sum;
      q = (mag << DEF_FRAC_BITS) / win_count;
      if (win_sum < 0) begin
        q = (q > (longint'(1) << (MEAN_BITS - 1))) ? -(longint'(1) << (MEAN_BITS - 1)) : -q;
      end else begin
        q = (q > (longint'(1) << (MEAN_BITS - 1)) - 1) ? (longint'(1) << (MEAN_BITS - 1)) - 1 : q;
      end
    end
    r.mean  = MEAN_BITS'(q);
    r.cnt   = COUNT_BITS'(win_count);
    r.front = (win_count != 0) ? win_samples[win_head] : '0;
    r.full  = (win_count == window_capacity());
    r.empty = (win_count == 0);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic void add_row(row_kind_t k, logic [COUNT_BITS-1:0] w, op_t op,
                                  logic signed [DEF_SAMPLE_BITS-1:0] s, bit typed,
                                  stats_t want);
    row_t row;
    row.kind   = k;
    row.window = w;
    row.op     = op;
    row.smp    = s;
    row.typed  = typed;
    row.want   = want;
    rows.push_back(row);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_request(op_t op, logic signed [DEF_SAMPLE_BITS-1:0] s, bit typed,
                              stats_t want);
    int gap;
    stats_t predicted;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    sample    <= s;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = compute_window_stats(op, s);
    expected_stats.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  task automatic write_window(logic [COUNT_BITS-1:0] value);
    req_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WINDOW_SIZE, 2'b00};
    pwdata  <= {27'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    win_reg   = value;
    win_head  = 0;
    win_count = 0;
    win_sum   = 0;
    window_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[COUNT_BITS-1:0] !== value) begin
      report_mismatch($sformatf("window_size read %0d, written %0d",
                                prdata[COUNT_BITS-1:0], value));
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    stats_t got;
    stats_t want;
    if (!rst && res_valid && !res_stall) begin
      got = '{mean_value, count, front_value, is_full, is_empty};
      if (expected_stats.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = expected_stats.pop_front();
        if (got.mean !== want.mean)
          report_mismatch($sformatf("mean_value got %0d expected %0d", got.mean, want.mean));
        if (got.cnt !== want.cnt)
          report_mismatch($sformatf("count got %0d expected %0d", got.cnt, want.cnt));
        if (got.front !== want.front)
          report_mismatch($sformatf("front_value got %0d expected %0d", got.front, want.front));
        if (got.full !== want.full)
          report_mismatch($sformatf("is_full got %0b expected %0b", got.full, want.full));
        if (got.empty !== want.empty)
          report_mismatch($sformatf("is_empty got %0b expected %0b", got.empty, want.empty));
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int len;
    res_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && results_checked >= HOLD_AFTER) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (no_idle) begin
        res_stall <= 1'b0;
        @(posedge clk);
      end else begin
        len = pick_gap();
        if (len == 0) begin
          res_stall <= 1'b0;
          repeat ($urandom_range(1, 40)) @(posedge clk);
        end else begin
          res_stall <= 1'b1;
          repeat (len) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int r;
    int pop_bias;
    op_t op;
    logic signed [DEF_SAMPLE_BITS-1:0] s;
    logic [COUNT_BITS-1:0] phase_windows [RANDOM_PHASES];

    clk       = 1'b0;
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    req_valid = 1'b0;
    operation = OP_NONE;
    sample    = '0;
    no_idle   = 1'b0;
    requests_sent   = 0;
    results_checked = 0;
    mismatches      = 0;
    window_writes   = 0;
    win_reg   = WS_RESET;
    win_head  = 0;
    win_count = 0;
    win_sum   = 0;
    pop_bias  = 30;

    add_row(ROW_REQUEST, 0, OP_POP, 16'sd0, 1, stats_t'{24'sd0, 5'd0, 16'sd0, 1'b0, 1'b1});
    add_row(ROW_REQUEST, 0, OP_NONE, 16'sh7fff, 1, stats_t'{24'sd0, 5'd0, 16'sd0, 1'b0, 1'b1});
    add_row(ROW_REQUEST, 0, OP_PUSH, 16'sd32767, 1,
            stats_t'{24'sd8388352, 5'd1, 16'sd32767, 1'b0, 1'b0});
    add_row(ROW_REQUEST, 0, OP_PUSH, 16'sh8000, 1,
            stats_t'{-24'sd128, 5'd2, 16'sd32767, 1'b0, 1'b0});
    add_row(ROW_REQUEST, 0, OP_PUSH, 16'sd1, 0, '0);
    add_row(ROW_REQUEST, 0, OP_SLIDE_PUSH, -16'sd1, 0, '0);
    add_row(ROW_REQUEST, 0, OP_PUSH, 16'sd5, 0, '0);
    add_row(ROW_REQUEST, 0, OP_SLIDE_PUSH, 16'sd100, 0, '0);
    add_row(ROW_REQUEST, 0, OP_NONE, 16'sd0, 0, '0);
    repeat (5) add_row(ROW_REQUEST, 0, OP_POP, 16'sh5a5a, 0, '0);
    add_row(ROW_WINDOW, 5'd1, OP_NONE, 16'sd0, 0, '0);
    add_row(ROW_REQUEST, 0, OP_SLIDE_PUSH, 16'sh8000, 1,
            stats_t'{24'sh800000, 5'd1, 16'sh8000, 1'b1, 1'b0});
    add_row(ROW_REQUEST, 0, OP_SLIDE_PUSH, 16'sd32767, 1,
            stats_t'{24'sd8388352, 5'd1, 16'sd32767, 1'b1, 1'b0});
    add_row(ROW_REQUEST, 0, OP_PUSH, 16'sd7, 1,
            stats_t'{24'sd8388352, 5'd1, 16'sd32767, 1'b1, 1'b0});
    add_row(ROW_REQUEST, 0, OP_POP, 16'sd0, 1, stats_t'{24'sd0, 5'd0, 16'sd0, 1'b0, 1'b1});
    add_row(ROW_WINDOW, 5'd0, OP_NONE, 16'sd0, 0, '0);
    add_row(ROW_REQUEST, 0, OP_SLIDE_PUSH, 16'sd3, 1,
            stats_t'{24'sd768, 5'd1, 16'sd3, 1'b1, 1'b0});
    add_row(ROW_REQUEST, 0, OP_PUSH, -16'sd3, 0, '0);
    add_row(ROW_WINDOW, 5'd16, OP_NONE, 16'sd0, 0, '0);
    add_row(ROW_REQUEST, 0, OP_SLIDE_PUSH, 16'sh8000, 0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WINDOW) begin
        write_window(rows[i].window);
      end else begin
        send_request(rows[i].op, rows[i].smp, rows[i].typed, rows[i].want);
      end
    end

    phase_windows[0] = 5'd16;
    phase_windows[1] = 5'd31;
    phase_windows[2] = 5'd1;
    phase_windows[3] = 5'd4;
    phase_windows[4] = 5'd0;
    phase_windows[5] = COUNT_BITS'($urandom_range(2, 15));
    phase_windows[6] = COUNT_BITS'($urandom_range(0, 31));
    phase_windows[7] = 5'd16;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_window(phase_windows[p]);
      no_idle = (p == 3);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 32 == 0) begin
          case ($urandom_range(2))
            0: pop_bias = 10;
            1: pop_bias = 35;
            default: pop_bias = 65;
          endcase
        end
        r = $urandom_range(99);
        if (r < 5) op = OP_NONE;
        else if (r < 5 + pop_bias) op = OP_POP;
        else if ($urandom_range(1) == 0) op = OP_SLIDE_PUSH;
        else op = OP_PUSH;
        r = $urandom_range(99);
        if (r < 12) begin
          case ($urandom_range(3))
            0: s = 16'sd32767;
            1: s = 16'sh8000;
            2: s = 16'sd0;
            default: s = -16'sd1;
          endcase
        end else begin
          s = DEF_SAMPLE_BITS'($urandom());
        end
        send_request(op, s, 0, '0);
      end
      no_idle = 1'b0;
    end

    req_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests across %0d window_size writes; %0d results compared.",
             requests_sent, window_writes, results_checked);
    $display("Receiver held off for %0d cycles once while requests kept arriving.", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
